// ===== rtl/kpi_pkg.sv =====
// Package for the keyframe pose interpolator: item structs, operation codes,
// sequencer states and shared constants. No dependencies.
package kpi_pkg;

  localparam int MOTIONS_DEF = 8;
  localparam int KEYS_DEF    = 16;
  localparam int PARTS_DEF   = 16;

  localparam int OUT_MAX   = 16;   // out_part is 4 bits
  localparam int PCW       = 5;    // part counter, holds 0..OUT_MAX
  localparam int POS_W     = 24;
  localparam int ROT_W     = 16;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_STEPS = 33;   // dividend bits of the scaled step
  localparam int DIVC_W    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_FRAMES = 1'd1;

  localparam logic [PCW-1:0] PART_COUNT_RST = 5'd16;
  localparam logic [7:0]     BLEND_RST      = 8'd7;

  typedef enum logic [2:0] {
    OP_KEY_POSE   = 3'd0,
    OP_KEY_FRAMES = 3'd1,
    OP_HEADER     = 3'd2,
    OP_REST_POSE  = 3'd3,
    OP_START      = 3'd4,
    OP_RESTART    = 3'd5,
    OP_TICK       = 3'd6
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_RD,
    ST_START_WR,
    ST_RST_RD,
    ST_RST_WR,
    ST_TICK_RD,
    ST_TICK_LD,
    ST_AXIS,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_EMIT,
    ST_TICK_END
  } state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [2:0]         motion_index;
    logic [3:0]         key_index;
    logic [3:0]         part_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic [7:0]         count_value;
    logic               loop_flag;
  } in_t;

  typedef struct packed {
    logic [3:0]         out_part;
    logic signed [23:0] out_pos_x;
    logic signed [23:0] out_pos_y;
    logic signed [23:0] out_pos_z;
    logic signed [15:0] out_rot_x;
    logic signed [15:0] out_rot_y;
    logic signed [15:0] out_rot_z;
    logic               finished;
    logic               last_part;
  } out_t;

endpackage

// ===== rtl/keyframe_pose_interpolator.sv =====
// Keyframe pose interpolator top level: command decode, sequencer, shared
// bit-serial divider datapath. Depends on kpi_pkg and kpi_ram.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  item in  | start, busy, item (in_t)       | taken when start && !busy
//  result   | res_strobe, result (out_t)     | one-cycle strobe, no stall
//  config   | cfg_we, cfg_index, cfg_data    | written when cfg_we is high
//
// Loads (key pose, key frames, header, rest pose) finish in the accept cycle.
// Start and restart walk the parts, each through a read state and a write state.
// A tick runs each emitted part through six axes, each with a multiply step and
// a 33-step restoring divide on the shared divider.
// Reset clears control state, headers and the valid bits of the per-part
// stores; key memories hold garbage until written. The receiver cannot stall:
// each result appears on the result ports for one cycle.
module keyframe_pose_interpolator
  import kpi_pkg::*;
#(
  parameter int MOTIONS = MOTIONS_DEF,
  parameter int KEYS    = KEYS_DEF,
  parameter int PARTS   = PARTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  item,
  output logic                 res_strobe,
  output out_t                 result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int PD   = (PARTS < 2) ? 2 : PARTS;
  localparam int PW   = $clog2(PD);
  localparam int KD   = MOTIONS * KEYS * PARTS;
  localparam int KAW  = $clog2(KD);
  localparam int FD   = MOTIONS * KEYS;
  localparam int FAW  = $clog2(FD);
  localparam int KW   = $clog2(KEYS);
  localparam int KTW  = $clog2(KEYS + 1);
  localparam int NMAX = (PARTS < OUT_MAX) ? PARTS : OUT_MAX;
  localparam int KPW  = 3 * POS_W + 3 * ROT_W;   // pos {z,y,x} over rot {z,y,x}
  localparam int RPW  = 3 * POS_W;
  localparam int CRW  = 3 * ROT_W;

  function automatic logic [KAW-1:0] key_addr(int m, int k, int p);
    return KAW'((m * KEYS + k) * PARTS + p);
  endfunction

  // control state
  state_t             state, state_next;
  logic [2:0]         act_motion;
  logic [KW-1:0]      cur_key, nxt_key;
  logic [7:0]         frame_cnt, seg_frames, frames_q;
  logic [KTW-1:0]     key_total;
  logic               loop_act, done_flag, adv_q, fin_q;
  logic [PCW-1:0]     part_count_r;
  logic [7:0]         blend_r;
  logic [KTW:0]       hdr [MOTIONS];
  logic [PCW-1:0]     pcnt;
  logic [2:0]         ax;
  logic [DIVC_W-1:0]  divc;
  logic [PD-1:0]      rest_vld, cur_vld, past_vld;
  logic               rest_vq, cur_vq, past_vq;

  // datapath
  logic [KPW-1:0]     op_key, op_past;
  logic [RPW-1:0]     op_rest;
  logic [RPW-1:0]     res_pos;
  logic [CRW-1:0]     res_rot;
  logic [24:0]        mag;
  logic               neg;
  logic [32:0]        acc;
  logic [7:0]         rem;

  // RAM ports
  logic [KPW-1:0]     key_rdata, past_rdata, past_wdata;
  logic [RPW-1:0]     rest_rdata;
  logic [CRW-1:0]     cur_rdata, cur_wdata;
  logic [7:0]         kf_rdata;
  logic               key_we, kf_we, rest_we, cur_we, past_we;
  logic [PW-1:0]      cur_waddr, prt_addr;
  logic [KW-1:0]      rd_key;
  logic [KAW-1:0]     key_raddr;

  // decode
  logic               acc_in, m_ok, k_ok, p_ok;
  logic [PCW-1:0]     n_act;
  logic [KTW-1:0]     keys_eff;
  logic [7:0]         frames_eff;
  logic [KW-1:0]      nxt_calc;
  logic               adv_calc;
  logic               last_p;

  assign busy   = (state != ST_IDLE);
  assign acc_in = start && !busy;
  assign m_ok   = int'(item.motion_index) < MOTIONS;
  assign k_ok   = int'(item.key_index) < KEYS;
  assign p_ok   = int'(item.part_index) < PARTS;
  assign n_act  = (int'(part_count_r) > NMAX) ? PCW'(NMAX) : part_count_r;
  assign last_p = (int'(pcnt) + 1 == int'(n_act));
  assign prt_addr = PW'(pcnt);

  // Segment bookkeeping for a tick, worked out at accept time.
  assign keys_eff   = (key_total == '0) ? KTW'(1) : key_total;
  assign frames_eff = (seg_frames == 8'd0) ? 8'd1 : seg_frames;
  assign nxt_calc   = (int'(cur_key) + 1 >= int'(keys_eff)) ? '0 : KW'(int'(cur_key) + 1);
  assign adv_calc   = ({1'b0, frame_cnt} + 9'd1) >= {1'b0, frames_eff};

  // Axis select for the shared datapath: axes 0..2 positions, 3..5 rotations.
  logic               pos_sel;
  logic [1:0]         ai;
  logic [23:0]        kp, pp, rp;
  logic [15:0]        kr, pr, dr;
  logic [24:0]        d25;
  logic [24:0]        q;
  logic [25:0]        step;
  logic [26:0]        vsum;
  logic [23:0]        vsat;
  logic [8:0]         rem_sh;
  logic               qbit;

  assign pos_sel = (ax < 3'd3);
  assign ai      = pos_sel ? ax[1:0] : 2'(ax - 3'd3);
  assign kp      = op_key[CRW + POS_W * ai +: POS_W];
  assign pp      = op_past[CRW + POS_W * ai +: POS_W];
  assign rp      = op_rest[POS_W * ai +: POS_W];
  assign kr      = op_key[ROT_W * ai +: ROT_W];
  assign pr      = op_past[ROT_W * ai +: ROT_W];
  assign dr      = kr - pr;
  assign d25     = pos_sel ? ({kp[23], kp} - {pp[23], pp}) : {{9{dr[15]}}, dr};

  assign rem_sh  = {rem, acc[32]};
  assign qbit    = (rem_sh >= {1'b0, frames_q});

  assign q       = acc[24:0];
  assign step    = neg ? (26'd0 - {1'b0, q}) : {1'b0, q};
  assign vsum    = {{3{rp[23]}}, rp} + {{3{pp[23]}}, pp} + {step[25], step};
  always_comb begin
    if ($signed(vsum) > 27'sd8388607) begin
      vsat = 24'h7FFFFF;
    end else if ($signed(vsum) < -27'sd8388608) begin
      vsat = 24'h800000;
    end else begin
      vsat = vsum[23:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc_in) begin
          if (item.operation == OP_START && m_ok) begin
            state_next = ST_START_RD;
          end else if (item.operation == OP_RESTART && m_ok) begin
            state_next = ST_RST_RD;
          end else if (item.operation == OP_TICK && !done_flag) begin
            state_next = ST_TICK_RD;
          end
        end
      end
      ST_START_RD: state_next = (pcnt >= n_act) ? ST_IDLE : ST_START_WR;
      ST_START_WR: state_next = ST_START_RD;
      ST_RST_RD:   state_next = (pcnt >= n_act) ? ST_IDLE : ST_RST_WR;
      ST_RST_WR:   state_next = ST_RST_RD;
      ST_TICK_RD:  state_next = (pcnt >= n_act) ? ST_TICK_END : ST_TICK_LD;
      ST_TICK_LD:  state_next = ST_AXIS;
      ST_AXIS:     state_next = ST_MUL;
      ST_MUL:      state_next = ST_DIV;
      ST_DIV:      state_next = (int'(divc) == DIV_STEPS - 1) ? ST_FIN : ST_DIV;
      ST_FIN:      state_next = (ax == 3'd5) ? ST_EMIT : ST_AXIS;
      ST_EMIT:     state_next = ST_TICK_RD;
      ST_TICK_END: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      act_motion   <= '0;
      cur_key      <= '0;
      nxt_key      <= '0;
      frame_cnt    <= '0;
      seg_frames   <= '0;
      frames_q     <= '0;
      key_total    <= '0;
      loop_act     <= 1'b0;
      done_flag    <= 1'b0;
      adv_q        <= 1'b0;
      fin_q        <= 1'b0;
      part_count_r <= PART_COUNT_RST;
      blend_r      <= BLEND_RST;
      pcnt         <= '0;
      ax           <= '0;
      divc         <= '0;
      rest_vld     <= '0;
      cur_vld      <= '0;
      past_vld     <= '0;
      for (int i = 0; i < MOTIONS; i++) begin
        hdr[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PART_COUNT:   part_count_r <= cfg_data[PCW-1:0];
          REG_BLEND_FRAMES: blend_r      <= cfg_data;
          default: ;
        endcase
      end

      if (acc_in) begin
        pcnt <= '0;
        if (item.operation == OP_HEADER && m_ok) begin
          hdr[item.motion_index] <= {item.loop_flag,
              (int'(item.count_value) > KEYS) ? KTW'(KEYS) : KTW'(item.count_value)};
        end
        if ((item.operation == OP_START || item.operation == OP_RESTART) && m_ok) begin
          // begin a motion: latch the header, rewind the segment
          act_motion <= item.motion_index;
          key_total  <= hdr[item.motion_index][KTW-1:0];
          loop_act   <= hdr[item.motion_index][KTW];
          cur_key    <= (item.operation == OP_RESTART) ? KW'(1) : '0;
          frame_cnt  <= '0;
          done_flag  <= 1'b0;
          seg_frames <= blend_r;
        end
        if (item.operation == OP_TICK && !done_flag) begin
          nxt_key  <= nxt_calc;
          frames_q <= frames_eff;
          adv_q    <= adv_calc;
          fin_q    <= adv_calc && (int'(nxt_calc) == int'(keys_eff) - 1) && !loop_act;
        end
      end

      if (rest_we) rest_vld[cur_waddr] <= 1'b1;
      if (cur_we)  cur_vld[cur_waddr]  <= 1'b1;
      if (past_we) past_vld[prt_addr]  <= 1'b1;

      if (state == ST_START_WR || state == ST_RST_WR || state == ST_EMIT) begin
        pcnt <= pcnt + PCW'(1);
      end
      if (state == ST_TICK_LD) ax <= '0;
      if (state == ST_FIN)     ax <= ax + 3'd1;
      if (state == ST_MUL)     divc <= '0;
      if (state == ST_DIV)     divc <= divc + DIVC_W'(1);

      if (state == ST_TICK_END) begin
        // close the tick: advance the key or count the frame
        if (adv_q) begin
          frame_cnt  <= '0;
          cur_key    <= nxt_key;
          seg_frames <= kf_rdata;
          done_flag  <= fin_q;
        end else begin
          frame_cnt <= frame_cnt + 8'd1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rest_vq <= rest_vld[prt_addr];
    cur_vq  <= cur_vld[prt_addr];
    past_vq <= past_vld[prt_addr];
    unique case (state)
      ST_TICK_LD: begin
        op_key  <= key_rdata;
        op_past <= past_vq ? past_rdata : '0;
        op_rest <= rest_vq ? rest_rdata : '0;
      end
      ST_AXIS: begin
        neg <= d25[24];
        mag <= d25[24] ? (25'd0 - d25) : d25;
      end
      ST_MUL: begin
        acc <= 33'(mag * frame_cnt) + 33'(frames_q >> 1);
        rem <= '0;
      end
      ST_DIV: begin
        rem <= qbit ? 8'(rem_sh - {1'b0, frames_q}) : rem_sh[7:0];
        acc <= {acc[31:0], qbit};
      end
      ST_FIN: begin
        if (pos_sel) begin
          res_pos[POS_W * ai +: POS_W] <= vsat;
        end else begin
          res_rot[ROT_W * ai +: ROT_W] <= pr + step[15:0];
        end
      end
      default: ;
    endcase
  end

  // memories
  always_comb begin
    unique case (state)
      ST_START_RD, ST_START_WR: rd_key = '0;
      ST_RST_RD, ST_RST_WR:     rd_key = KW'(1);
      default:                  rd_key = nxt_key;
    endcase
  end

  assign key_raddr = key_addr(int'(act_motion), int'(rd_key), int'(pcnt));
  assign key_we    = acc_in && item.operation == OP_KEY_POSE && m_ok && k_ok && p_ok;
  assign kf_we     = acc_in && item.operation == OP_KEY_FRAMES && m_ok && k_ok;
  assign rest_we   = acc_in && item.operation == OP_REST_POSE && p_ok;

  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = prt_addr;
    cur_wdata = key_rdata[CRW-1:0];
    past_we   = 1'b0;
    past_wdata = key_rdata;
    priority if (rest_we) begin
      cur_we    = 1'b1;
      cur_waddr = PW'(item.part_index);
      cur_wdata = {item.rot_z, item.rot_y, item.rot_x};
    end else if (state == ST_START_WR) begin
      past_we    = 1'b1;
      past_wdata = {key_rdata[KPW-1:CRW], cur_vq ? cur_rdata : {CRW{1'b0}}};
    end else if (state == ST_RST_WR) begin
      cur_we  = 1'b1;
      past_we = 1'b1;
    end else if (state == ST_EMIT) begin
      // on a key change the part restarts from the new key pose
      cur_we     = 1'b1;
      cur_wdata  = adv_q ? op_key[CRW-1:0] : res_rot;
      past_we    = adv_q;
      past_wdata = op_key;
    end else begin
      cur_we = 1'b0;
    end
  end

  kpi_ram #(.WIDTH(KPW), .DEPTH(KD)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_addr(int'(item.motion_index), int'(item.key_index), int'(item.part_index))),
    .wdata ({item.pos_z, item.pos_y, item.pos_x, item.rot_z, item.rot_y, item.rot_x}),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  kpi_ram #(.WIDTH(8), .DEPTH(FD)) u_kf_ram (
    .clk   (clk),
    .we    (kf_we),
    .waddr (FAW'(int'(item.motion_index) * KEYS + int'(item.key_index))),
    .wdata (item.count_value),
    .raddr (FAW'(int'(act_motion) * KEYS + int'(nxt_key))),
    .rdata (kf_rdata)
  );

  kpi_ram #(.WIDTH(RPW), .DEPTH(PD)) u_rest_ram (
    .clk   (clk),
    .we    (rest_we),
    .waddr (PW'(item.part_index)),
    .wdata ({item.pos_z, item.pos_y, item.pos_x}),
    .raddr (prt_addr),
    .rdata (rest_rdata)
  );

  kpi_ram #(.WIDTH(CRW), .DEPTH(PD)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (prt_addr),
    .rdata (cur_rdata)
  );

  kpi_ram #(.WIDTH(KPW), .DEPTH(PD)) u_past_ram (
    .clk   (clk),
    .we    (past_we),
    .waddr (prt_addr),
    .wdata (past_wdata),
    .raddr (prt_addr),
    .rdata (past_rdata)
  );

  // result register: one strobe per emitted pose
  always_ff @(posedge clk) begin
    if (rst) begin
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= (state == ST_EMIT) || (state == ST_RST_WR);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RST_WR) begin
      result.out_part  <= pcnt[3:0];
      result.out_pos_x <= key_rdata[CRW +: POS_W];
      result.out_pos_y <= key_rdata[CRW + POS_W +: POS_W];
      result.out_pos_z <= key_rdata[CRW + 2 * POS_W +: POS_W];
      result.out_rot_x <= key_rdata[0 +: ROT_W];
      result.out_rot_y <= key_rdata[ROT_W +: ROT_W];
      result.out_rot_z <= key_rdata[2 * ROT_W +: ROT_W];
      result.finished  <= 1'b0;
      result.last_part <= last_p;
    end else begin
      result.out_part  <= pcnt[3:0];
      result.out_pos_x <= res_pos[0 +: POS_W];
      result.out_pos_y <= res_pos[POS_W +: POS_W];
      result.out_pos_z <= res_pos[2 * POS_W +: POS_W];
      result.out_rot_x <= res_rot[0 +: ROT_W];
      result.out_rot_y <= res_rot[ROT_W +: ROT_W];
      result.out_rot_z <= res_rot[2 * ROT_W +: ROT_W];
      result.finished  <= fin_q;
      result.last_part <= last_p;
    end
  end

  // checks
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    res_strobe |-> $past(busy)) else $error("result strobe outside a run");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !busy) else $error("busy right after reset");

  a_done_tick: assert property (@(posedge clk) disable iff (rst)
    (acc_in && item.operation == OP_TICK && done_flag) |=> !busy)
    else $error("tick ran on a finished motion");

  a_div_frames: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (frames_q != 8'd0)) else $error("divide by zero frames");

endmodule

// ===== rtl/kpi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
